// ===== sv/ucs_pkg.sv =====
`default_nettype none
package ucs_pkg;

   localparam int CntWidth = 32;
   localparam logic [CntWidth-1:0] CntMax = {CntWidth{1'b1}};

   localparam logic [CntWidth-1:0] HourTicksReset = 32'd720000;
   localparam logic [CntWidth-1:0] AutoTicksReset = 32'd360000;
   localparam logic [CntWidth-1:0] DayTicksReset  = 32'd17280000;

   typedef enum logic [1:0] {
      PH_WAIT_HOUR = 2'd0,
      PH_AUTO      = 2'd1,
      PH_WAIT_DAY  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      LED_OFF   = 2'd0,
      LED_GREEN = 2'd1,
      LED_BLUE  = 2'd2,
      LED_RED   = 2'd3
   } led_type;

   // sequencer state carried between the top level and the step logic
   typedef struct packed {
      phase_type             phase;
      logic                  fault;
      logic                  drive;
      led_type               led;
      logic [CntWidth-1:0]   day_count;
      logic [CntWidth-1:0]   auto_count;
   } seq_state_type;

   typedef struct packed {
      logic [CntWidth-1:0] hour_ticks;
      logic [CntWidth-1:0] auto_ticks;
      logic [CntWidth-1:0] day_ticks;
   } seq_cfg_type;

endpackage
`default_nettype wire

// ===== sv/ucs_step.sv =====
`default_nettype none
// One tick of the sequencer: counters, lid interlock, phase transition.
module ucs_step (
   input  wire ucs_pkg::seq_state_type cur,
   input  wire ucs_pkg::seq_cfg_type   cfg,
   input  wire logic                   lid_open,
   output ucs_pkg::seq_state_type      nxt
);

   logic in_auto;

   always_comb begin
      nxt     = cur;
      in_auto = (cur.phase == ucs_pkg::PH_AUTO);

      // saturating tick counters
      if (cur.day_count != ucs_pkg::CntMax) begin
         nxt.day_count = cur.day_count + ucs_pkg::CntWidth'(1);
      end
      if (in_auto && (cur.auto_count != ucs_pkg::CntMax)) begin
         nxt.auto_count = cur.auto_count + ucs_pkg::CntWidth'(1);
      end

      // lid interlock
      if (lid_open) begin
         if (!cur.fault) begin
            nxt.led = ucs_pkg::LED_RED;
            if (in_auto) begin
               nxt.drive = 1'b0;
            end
         end
         nxt.fault = 1'b1;
      end else begin
         if (cur.fault) begin
            if (in_auto) begin
               nxt.drive = 1'b1;
               nxt.led   = ucs_pkg::LED_BLUE;
            end else begin
               nxt.led = ucs_pkg::LED_GREEN;
            end
         end
         nxt.fault = 1'b0;
      end

      // phase end conditions
      case (cur.phase)
         ucs_pkg::PH_WAIT_HOUR: begin
            if (nxt.day_count >= cfg.hour_ticks) begin
               if (!nxt.fault) begin
                  nxt.drive = 1'b1;
                  nxt.led   = ucs_pkg::LED_BLUE;
               end
               nxt.phase      = ucs_pkg::PH_AUTO;
               nxt.auto_count = '0;
            end
         end
         ucs_pkg::PH_AUTO: begin
            if (nxt.auto_count >= cfg.auto_ticks) begin
               nxt.drive = 1'b0;
               if (!nxt.fault) begin
                  nxt.led = ucs_pkg::LED_GREEN;
               end
               nxt.phase = ucs_pkg::PH_WAIT_DAY;
            end
         end
         ucs_pkg::PH_WAIT_DAY: begin
            if (nxt.day_count >= cfg.day_ticks) begin
               nxt.phase     = ucs_pkg::PH_WAIT_HOUR;
               nxt.day_count = '0;
               if (!nxt.fault) begin
                  nxt.led = ucs_pkg::LED_GREEN;
               end
            end
         end
         default: begin
            // unused phase code: restart the day
            nxt.drive     = 1'b0;
            nxt.phase     = ucs_pkg::PH_WAIT_HOUR;
            nxt.day_count = '0;
            if (!nxt.fault) begin
               nxt.led = ucs_pkg::LED_GREEN;
            end
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/uv_cycle_sequencer_with_lid_interlock_core.sv =====
`default_nettype none
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+-------------------------------------
// request   | in        | req_valid / req_ready   | req_lid_open
// response  | out       | rsp_valid / rsp_ready   | rsp_phase, rsp_lid_fault,
//           |           |                         | rsp_uv_drive, rsp_led_color
// csr       | in/out    | APB psel/penable/pready | paddr, pwdata, prdata
//
// One request per cycle while the response is not stalled; a request passes
// through the input register, then the state update lands in the response
// register. The tick update loop through the state registers sets the rate.
// Reset (synchronous, active high) clears both pipeline stages, the phase
// state and counters, and loads the default tick limits.
// A stalled response holds the pipeline; req_ready drops only when the input
// register is full and cannot move into a stalled response register.
module uv_cycle_sequencer_with_lid_interlock_core (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_lid_open,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_phase,
   output logic             rsp_lid_fault,
   output logic             rsp_uv_drive,
   output logic [1:0]       rsp_led_color,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // register indexes (byte address / 4)
   localparam logic [1:0] RegHour = 2'd0;
   localparam logic [1:0] RegAuto = 2'd1;
   localparam logic [1:0] RegDay  = 2'd2;

   ucs_pkg::seq_cfg_type   cfg_ff;
   ucs_pkg::seq_state_type state_ff;
   ucs_pkg::seq_state_type state_in;

   logic       s1_valid_ff;
   logic       s1_lid_ff;
   logic       s1_advance;

   logic       rsp_valid_ff;
   logic [1:0] rsp_phase_ff;
   logic       rsp_fault_ff;
   logic       rsp_drive_ff;
   logic [1:0] rsp_led_ff;

   logic       csr_write;
   logic [1:0] csr_index;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hour_ticks <= ucs_pkg::HourTicksReset;
         cfg_ff.auto_ticks <= ucs_pkg::AutoTicksReset;
         cfg_ff.day_ticks  <= ucs_pkg::DayTicksReset;
      end else if (csr_write) begin
         case (csr_index)
            RegHour: cfg_ff.hour_ticks <= pwdata;
            RegAuto: cfg_ff.auto_ticks <= pwdata;
            RegDay:  cfg_ff.day_ticks  <= pwdata;
            default: ; // beyond the register list: ignored
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         RegHour: prdata = cfg_ff.hour_ticks;
         RegAuto: prdata = cfg_ff.auto_ticks;
         RegDay:  prdata = cfg_ff.day_ticks;
         default: prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // Stage 1 moves into the response register when that register is empty
   // or being drained this cycle; the state update happens on that move.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_lid_ff <= req_lid_open;
      end
   end

   // ---------------- tick update ----------------
   ucs_step u_step (
      .cur      (state_ff),
      .cfg      (cfg_ff),
      .lid_open (s1_lid_ff),
      .nxt      (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= ucs_pkg::PH_WAIT_HOUR;
         state_ff.fault      <= 1'b0;
         state_ff.drive      <= 1'b0;
         state_ff.led        <= ucs_pkg::LED_GREEN;
         state_ff.day_count  <= '0;
         state_ff.auto_count <= '0;
      end else if (s1_advance) begin
         state_ff <= state_in;
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_phase_ff <= state_in.phase;
         rsp_fault_ff <= state_in.fault;
         rsp_drive_ff <= state_in.drive;
         rsp_led_ff   <= state_in.led;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phase     = rsp_phase_ff;
   assign rsp_lid_fault = rsp_fault_ff;
   assign rsp_uv_drive  = rsp_drive_ff;
   assign rsp_led_color = rsp_led_ff;

endmodule
`default_nettype wire

// ===== sv/ucs_checker.sv =====
`default_nettype none
module ucs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_phase,
   input wire logic       rsp_lid_fault,
   input wire logic       rsp_uv_drive,
   input wire logic [1:0] rsp_led_color
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase) &&
      $stable(rsp_lid_fault) && $stable(rsp_uv_drive) && $stable(rsp_led_color))
      else $error("stalled response changed");

   // red LED exactly while the fault is latched
   a_red_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lid_fault == (rsp_led_color == ucs_pkg::LED_RED)))
      else $error("LED red does not track lid fault");

   // drive only in auto phase, lid closed, blue LED
   a_drive_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_uv_drive |->
      rsp_phase == ucs_pkg::PH_AUTO && !rsp_lid_fault &&
      rsp_led_color == ucs_pkg::LED_BLUE)
      else $error("UV drive on outside closed-lid auto phase");

   // unused phase code never reported
   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_phase == ucs_pkg::PH_WAIT_HOUR || rsp_phase == ucs_pkg::PH_AUTO ||
                     rsp_phase == ucs_pkg::PH_WAIT_DAY))
      else $error("unused phase code");

endmodule

bind uv_cycle_sequencer_with_lid_interlock_core ucs_checker u_ucs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_phase     (rsp_phase),
   .rsp_lid_fault (rsp_lid_fault),
   .rsp_uv_drive  (rsp_uv_drive),
   .rsp_led_color (rsp_led_color)
);
`default_nettype wire
